@@ sv/spq_pkg.sv @@
// Package for the stable priority queue with update.
// Holds the entry layout, operation and status codes, and cell control types.
// Used by spq_cell and stable_priority_queue_with_update_core.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	// Default number of entries the queue can hold.
	localparam int SPQ_DEPTH = 16;

	// New priorities that also set the condition code.
	localparam logic [7:0] PRIO_NORMAL   = 8'd1;
	localparam logic [7:0] PRIO_URGENT   = 8'd2;
	localparam logic [7:0] PRIO_CRITICAL = 8'd3;

	// One stored entry; all fields take part in the update match.
	typedef struct packed {
		logic [15:0] id;
		logic [6:0]  age;
		logic [2:0]  cond;
		logic [7:0]  prio;
	} spq_entry_t;

	// Operation codes of a request.
	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_POP    = 2'd1,
		FN_UPDATE = 2'd2,
		FN_NOP    = 2'd3
	} spq_func_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_EMPTY    = 3'd1,
		STS_FULL     = 3'd2,
		STS_NOTFOUND = 3'd3,
		STS_SAME     = 3'd4
	} spq_status_t;

	// What every cell does in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2,
		CELL_REMOVE = 2'd3
	} spq_cell_op_t;

	// Control broadcast to the whole row of cells.
	typedef struct packed {
		spq_cell_op_t op;
		spq_entry_t   ent;
	} spq_cell_ctl_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_REINS = 2'd1,
		ST_RESP  = 2'd2
	} spq_state_t;

endpackage

`default_nettype wire

@@ sv/spq_cell.sv @@
// One cell of the sorted queue row: holds a single entry.
// Exchanges entries and chain flags with its neighbors; depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic          clk,
	input  wire spq_cell_ctl_t ctl,
	input  wire logic          occ,
	input  wire logic          left_ge,
	input  wire logic          left_found,
	input  wire spq_entry_t    left_ent,
	input  wire spq_entry_t    right_ent,
	output spq_entry_t         ent,
	output logic               ge,
	output logic               found
);

	spq_entry_t ent_q;
	spq_entry_t ent_d;
	logic       hit;

	// Local compare against the broadcast entry.
	always_comb begin
		hit   = occ && (ent_q == ctl.ent);
		ge    = occ && (ent_q.prio >= ctl.ent.prio);
		found = left_found | hit;
	end

	// Next content: keep, take the new entry, or take a neighbor's entry.
	always_comb begin
		case (ctl.op)
			CELL_HOLD: begin
				ent_d = ent_q;
			end
			CELL_INSERT: begin
				if (ge)
					ent_d = ent_q;
				else if (left_ge)
					ent_d = ctl.ent;
				else
					ent_d = left_ent;
			end
			CELL_SHIFT: begin
				ent_d = right_ent;
			end
			CELL_REMOVE: begin
				ent_d = found ? right_ent : ent_q;
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	// Entry register; content beyond the fill count is never shown.
	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign ent = ent_q;

endmodule

`default_nettype wire

@@ sv/stable_priority_queue_with_update_core.sv @@
// Top level of the stable priority queue with update.
// Builds the row of spq_cell instances and the controller; depends on spq_pkg.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   Its fields are func, entry_id, entry_age, entry_condition, entry_priority
//   and target_priority. Each request gives exactly one result, shown for one
//   cycle with done high: status, count and the head entry (on a successful
//   pop, the removed entry). The receiver cannot stall the result.
// Timing:
//   Insert and pop requests change the cell row at the accepting edge;
//   these and refused requests show the result in the next cycle.
//   A successful update removes the entry at the accepting edge, re-inserts
//   it in the next cycle through the same row, and shows the result in
//   ST_RESP once that re-insertion is done. busy stays high until the result
//   cycle is over. Every cell works in parallel; the row takes a single shared
//   broadcast of one entry per cycle.
// Reset:
//   arst_n clears the fill count and the controller; the queue is empty and
//   ready at once. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_with_update_core
	import spq_pkg::*;
#(
	parameter int DEPTH = SPQ_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] entry_id,
	input  wire logic [6:0]  entry_age,
	input  wire logic [2:0]  entry_condition,
	input  wire logic [7:0]  entry_priority,
	input  wire logic [7:0]  target_priority,
	output logic             done,
	output logic [2:0]       status,
	output logic [4:0]       count,
	output logic             head_valid,
	output logic [15:0]      head_id,
	output logic [6:0]       head_age,
	output logic [2:0]       head_condition,
	output logic [7:0]       head_priority
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	spq_state_t     state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	spq_status_t    status_q, status_d;
	logic           pop_q, pop_d;
	spq_entry_t     popped_q;
	spq_entry_t     moved_q;
	spq_entry_t     moved_d;

	spq_entry_t     req_ent;
	spq_func_t      req_func;
	spq_cell_ctl_t  ctl;
	logic           accept;
	logic           full;
	logic           empty;
	logic           found_any;
	logic           do_insert, do_pop, do_remove;

	spq_entry_t     ent_w   [DEPTH];
	logic           ge_w    [DEPTH];
	logic           found_w [DEPTH];
	logic           occ_w   [DEPTH];

	logic [CNT_W+4:0] count_ext;

	// Request decode.
	always_comb begin
		req_ent.id   = entry_id;
		req_ent.age  = entry_age;
		req_ent.cond = entry_condition;
		req_ent.prio = entry_priority;
		req_func     = spq_func_t'(func);
		accept       = start && (state_q == ST_IDLE);
		full         = (count_q == CNT_W'(DEPTH));
		empty        = (count_q == '0);
		found_any    = found_w[DEPTH-1];
	end

	// Entry re-inserted by an update: new priority, condition set for 1 to 3.
	always_comb begin
		moved_d      = req_ent;
		moved_d.prio = target_priority;
		if (target_priority == PRIO_NORMAL || target_priority == PRIO_URGENT ||
				target_priority == PRIO_CRITICAL)
			moved_d.cond = target_priority[2:0];
	end

	// Request outcome, decided in the accepting cycle.
	always_comb begin
		do_insert = 1'b0;
		do_pop    = 1'b0;
		do_remove = 1'b0;
		status_d  = STS_OK;
		case (req_func)
			FN_INSERT: begin
				if (full)
					status_d = STS_FULL;
				else
					do_insert = 1'b1;
			end
			FN_POP: begin
				if (empty)
					status_d = STS_EMPTY;
				else
					do_pop = 1'b1;
			end
			FN_UPDATE: begin
				if (empty)
					status_d = STS_EMPTY;
				else if (entry_priority == target_priority)
					status_d = STS_SAME;
				else if (!found_any)
					status_d = STS_NOTFOUND;
				else
					do_remove = 1'b1;
			end
			default: begin
				status_d = STS_OK;
			end
		endcase
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = do_remove ? ST_REINS : ST_RESP;
			end
			ST_REINS: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs: handshake, cell row command and fill count.
	always_comb begin
		busy    = (state_q != ST_IDLE);
		done    = (state_q == ST_RESP);
		ctl.op  = CELL_HOLD;
		ctl.ent = req_ent;
		count_d = count_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && do_insert) begin
					ctl.op  = CELL_INSERT;
					count_d = count_q + CNT_W'(1);
				end else if (accept && do_pop) begin
					ctl.op  = CELL_SHIFT;
					count_d = count_q - CNT_W'(1);
				end else if (accept && do_remove) begin
					ctl.op  = CELL_REMOVE;
					count_d = count_q - CNT_W'(1);
				end
			end
			ST_REINS: begin
				ctl.op  = CELL_INSERT;
				ctl.ent = moved_q;
				count_d = count_q + CNT_W'(1);
			end
			default: begin
				ctl.op = CELL_HOLD;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			status_q <= STS_OK;
			pop_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (accept) begin
				status_q <= status_d;
				pop_q    <= pop_d;
			end
		end
	end

	assign pop_d = do_pop;

	// Payload registers: removed head and the entry waiting for re-insertion.
	always_ff @(posedge clk) begin
		if (accept && do_pop)
			popped_q <= ent_w[0];
		if (accept && do_remove)
			moved_q <= moved_d;
	end

	// Row of cells, each talking to its neighbors only.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic       left_ge_c;
		logic       left_found_c;
		spq_entry_t left_ent_c;
		spq_entry_t right_ent_c;

		assign occ_w[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_ge_c    = 1'b1;
			assign left_found_c = 1'b0;
			assign left_ent_c   = ent_w[0];
		end else begin : g_inner
			assign left_ge_c    = ge_w[i-1];
			assign left_found_c = found_w[i-1];
			assign left_ent_c   = ent_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_ent_c = ent_w[i];
		end else begin : g_mid
			assign right_ent_c = ent_w[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.occ        (occ_w[i]),
			.left_ge    (left_ge_c),
			.left_found (left_found_c),
			.left_ent   (left_ent_c),
			.right_ent  (right_ent_c),
			.ent        (ent_w[i]),
			.ge         (ge_w[i]),
			.found      (found_w[i])
		);
	end

	// Result fields: removed entry after a pop, otherwise the current head.
	always_comb begin
		count_ext  = {5'b0, count_q};
		status     = status_q;
		count      = count_ext[4:0];
		head_valid = pop_q || !empty;
		if (pop_q) begin
			head_id        = popped_q.id;
			head_age       = popped_q.age;
			head_condition = popped_q.cond;
			head_priority  = popped_q.prio;
		end else if (!empty) begin
			head_id        = ent_w[0].id;
			head_age       = ent_w[0].age;
			head_condition = ent_w[0].cond;
			head_priority  = ent_w[0].prio;
		end else begin
			head_id        = '0;
			head_age       = '0;
			head_condition = '0;
			head_priority  = '0;
		end
	end

	// The fill count never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count exceeds depth");

	// A re-insertion always has a free slot and is followed by the result.
	a_reins_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REINS |-> count_q < CNT_W'(DEPTH))
		else $error("re-insertion into a full row");

	a_reins_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REINS |=> state_q == ST_RESP)
		else $error("re-insertion not followed by result");

	// A full report leaves the queue full.
	a_full_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && status_q == STS_FULL) |-> count_q == CNT_W'(DEPTH))
		else $error("full status with room left");

	// A successful update keeps the count it had before the request.
	a_update_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REINS |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("update changed the fill count");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for stable_priority_queue_with_update_core.
// Drives directed and random requests and checks every result against a local queue model or a fixed expectation.
// Depends on spq_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
	import spq_pkg::*;

	localparam int DEPTH = SPQ_DEPTH;
	localparam int RANDOM_REQUESTS = 1550;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS = 10;

	// One request as it goes onto the ports.
	typedef struct packed {
		spq_func_t  fn;
		spq_entry_t ent;
		logic [7:0] np;
	} queue_req_t;

	// One result as it comes off the ports.
	typedef struct packed {
		spq_status_t st;
		logic [4:0]  cnt;
		logic        hv;
		spq_entry_t  head;
	} queue_res_t;

	// A directed row: the request, and a fixed expectation where typed is set.
	typedef struct packed {
		spq_func_t   fn;
		logic [15:0] id;
		logic [6:0]  age;
		logic [2:0]  cond;
		logic [7:0]  prio;
		logic [7:0]  np;
		logic        typed;
		spq_status_t st;
		logic [4:0]  cnt;
		logic        hv;
		spq_entry_t  head;
	} plan_row_t;

	localparam spq_entry_t NO_HEAD = '0;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [15:0] entry_id;
	logic [6:0]  entry_age;
	logic [2:0]  entry_condition;
	logic [7:0]  entry_priority;
	logic [7:0]  target_priority;
	logic        done;
	logic [2:0]  status;
	logic [4:0]  count;
	logic        head_valid;
	logic [15:0] head_id;
	logic [6:0]  head_age;
	logic [2:0]  head_condition;
	logic [7:0]  head_priority;

	// Model state: entries in queue order, head first.
	spq_entry_t held_entries[$];
	// Results predicted for accepted requests, oldest first.
	queue_res_t pending_results[$];

	bit idle_ok;
	int fail_count;
	int stall_cycles;
	int results_seen;
	int n_insert, n_pop, n_update, n_nop;
	int n_full, n_empty, n_moved, n_notfound, n_same;

	// Directed requests in order; rows with typed set carry a fixed expected
	// result, the other rows are checked against the model.
	plan_row_t directed_plan [25] = '{
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b1, STS_EMPTY, 5'd0, 1'b0,
			NO_HEAD},
		'{FN_UPDATE, 16'h0000, 7'd0,   3'd0, 8'd0,   8'd5,   1'b1, STS_EMPTY, 5'd0, 1'b0,
			NO_HEAD},
		'{FN_NOP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b1, STS_OK,    5'd0, 1'b0,
			NO_HEAD},
		'{FN_INSERT, 16'hffff, 7'd127, 3'd7, 8'd255, 8'd0,   1'b1, STS_OK,    5'd1, 1'b1,
			'{16'hffff, 7'd127, 3'd7, 8'd255}},
		'{FN_INSERT, 16'h0000, 7'd0,   3'd0, 8'd0,   8'd255, 1'b1, STS_OK,    5'd2, 1'b1,
			'{16'hffff, 7'd127, 3'd7, 8'd255}},
		'{FN_INSERT, 16'h1234, 7'd5,   3'd1, 8'd255, 8'd0,   1'b1, STS_OK,    5'd3, 1'b1,
			'{16'hffff, 7'd127, 3'd7, 8'd255}},
		'{FN_UPDATE, 16'h1234, 7'd5,   3'd1, 8'd255, 8'd255, 1'b1, STS_SAME,  5'd3, 1'b1,
			'{16'hffff, 7'd127, 3'd7, 8'd255}},
		'{FN_UPDATE, 16'h0000, 7'd1,   3'd0, 8'd0,   8'd9,   1'b1, STS_NOTFOUND, 5'd3, 1'b1,
			'{16'hffff, 7'd127, 3'd7, 8'd255}},
		'{FN_UPDATE, 16'h7777, 7'd9,   3'd2, 8'd40,  8'd40,  1'b1, STS_SAME,  5'd3, 1'b1,
			'{16'hffff, 7'd127, 3'd7, 8'd255}},
		'{FN_UPDATE, 16'hffff, 7'd127, 3'd7, 8'd255, 8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_UPDATE, 16'h0000, 7'd0,   3'd0, 8'd0,   8'd2,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_UPDATE, 16'h0000, 7'd0,   3'd2, 8'd2,   8'd1,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_UPDATE, 16'h0000, 7'd0,   3'd1, 8'd1,   8'd3,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_UPDATE, 16'h1234, 7'd5,   3'd1, 8'd255, 8'd3,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_INSERT, 16'h55aa, 7'd64,  3'd4, 8'd3,   8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_NOP,    16'h0f0f, 7'd33,  3'd5, 8'd77,  8'd12,  1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_UPDATE, 16'h1234, 7'd5,   3'd1, 8'd3,   8'd7,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_UPDATE, 16'h0000, 7'd0,   3'd3, 8'd4,   8'd9,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b1, STS_EMPTY, 5'd0, 1'b0,
			NO_HEAD},
		'{FN_INSERT, 16'haaaa, 7'h55,  3'd2, 8'd128, 8'd0,   1'b0, STS_OK, 5'd0, 1'b0, NO_HEAD},
		'{FN_POP,    16'h0000, 7'd0,   3'd0, 8'd0,   8'd0,   1'b1, STS_OK,    5'd0, 1'b1,
			'{16'haaaa, 7'h55, 3'd2, 8'd128}}
	};

	stable_priority_queue_with_update_core #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.entry_id(entry_id),
		.entry_age(entry_age),
		.entry_condition(entry_condition),
		.entry_priority(entry_priority),
		.target_priority(target_priority),
		.done(done),
		.status(status),
		.count(count),
		.head_valid(head_valid),
		.head_id(head_id),
		.head_age(head_age),
		.head_condition(head_condition),
		.head_priority(head_priority)
	);

	// Free-running clock, 12 ns period.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Puts an entry behind all entries of greater or equal priority.
	function automatic void place_entry(input spq_entry_t e);
		int pos;
		pos = 0;
		while (pos < held_entries.size() && held_entries[pos].prio >= e.prio)
			pos++;
		held_entries.insert(pos, e);
	endfunction

	// Applies one request to the model queue and returns the result it gives.
	function automatic queue_res_t queue_model_apply(input queue_req_t r);
		queue_res_t res;
		spq_entry_t moved;
		int found;
		res = '0;
		res.st = STS_OK;
		case (r.fn)
			FN_INSERT: begin
				if (held_entries.size() >= DEPTH)
					res.st = STS_FULL;
				else
					place_entry(r.ent);
			end
			FN_POP: begin
				if (held_entries.size() == 0) begin
					res.st = STS_EMPTY;
				end else begin
					res.head = held_entries[0];
					res.hv = 1'b1;
					held_entries.delete(0);
				end
			end
			FN_UPDATE: begin
				// The same-priority check comes before the search.
				if (held_entries.size() == 0) begin
					res.st = STS_EMPTY;
				end else if (r.ent.prio == r.np) begin
					res.st = STS_SAME;
				end else begin
					found = -1;
					for (int k = 0; k < held_entries.size() && found < 0; k++)
						if (held_entries[k] == r.ent)
							found = k;
					if (found < 0) begin
						res.st = STS_NOTFOUND;
					end else begin
						moved = held_entries[found];
						held_entries.delete(found);
						moved.prio = r.np;
						if (r.np == PRIO_NORMAL || r.np == PRIO_URGENT || r.np == PRIO_CRITICAL)
							moved.cond = r.np[2:0];
						place_entry(moved);
					end
				end
			end
			default: ;
		endcase
		if (!res.hv && held_entries.size() != 0) begin
			res.head = held_entries[0];
			res.hv = 1'b1;
		end
		res.cnt = 5'(held_entries.size());
		return res;
	endfunction

	// Random request; most updates name a held entry, some with one field disturbed.
	function automatic queue_req_t pick_request(input int insert_pct);
		queue_req_t r;
		int roll;
		int which;
		roll = $urandom_range(99);
		r.ent.id = $urandom_range(1) ? 16'($urandom_range(3)) : 16'($urandom);
		r.ent.age = $urandom_range(1) ? 7'($urandom_range(1)) : 7'($urandom);
		r.ent.cond = 3'($urandom);
		r.ent.prio = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom);
		which = $urandom_range(9);
		r.np = (which < 3) ? 8'($urandom_range(3, 1)) :
			(which < 6) ? 8'($urandom_range(7)) : 8'($urandom);
		if (roll < 3) begin
			r.fn = FN_NOP;
		end else if (roll < 3 + insert_pct) begin
			r.fn = FN_INSERT;
		end else if (roll < 3 + insert_pct + (97 - insert_pct) / 2) begin
			r.fn = FN_POP;
		end else begin
			r.fn = FN_UPDATE;
			if (held_entries.size() != 0 && $urandom_range(9) < 8) begin
				r.ent = held_entries[$urandom_range(held_entries.size() - 1)];
				which = $urandom_range(9);
				case (which)
					0: r.ent.id ^= 16'(1 << $urandom_range(15));
					1: r.ent.age ^= 7'(1 << $urandom_range(6));
					2: r.ent.cond ^= 3'(1 << $urandom_range(2));
					3: r.ent.prio ^= 8'(1 << $urandom_range(7));
					default: ;
				endcase
				if ($urandom_range(9) == 0)
					r.np = r.ent.prio;
			end
		end
		return r;
	endfunction

	// Presents one request from a falling edge, holds it until accepted, and
	// records what it should produce.
	task automatic issue_request(input queue_req_t r, input bit typed, input queue_res_t fixed);
		queue_res_t model_res;
		while (idle_ok && $urandom_range(99) < 36) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		func <= r.fn;
		entry_id <= r.ent.id;
		entry_age <= r.ent.age;
		entry_condition <= r.ent.cond;
		entry_priority <= r.ent.prio;
		target_priority <= r.np;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model_res = queue_model_apply(r);
		pending_results.push_back(typed ? fixed : model_res);
		case (r.fn)
			FN_INSERT: n_insert++;
			FN_POP:    n_pop++;
			FN_UPDATE: n_update++;
			default:   n_nop++;
		endcase
		case (model_res.st)
			STS_FULL:     n_full++;
			STS_EMPTY:    n_empty++;
			STS_NOTFOUND: n_notfound++;
			STS_SAME:     n_same++;
			default:      if (r.fn == FN_UPDATE) n_moved++;
		endcase
		@(negedge clk);
	endtask

	// Result checker and watchdog.
	always @(posedge clk) begin
		queue_res_t got;
		queue_res_t want;
		if (arst_n) begin
			if (done) begin
				results_seen++;
				got.st = spq_status_t'(status);
				got.cnt = count;
				got.hv = head_valid;
				got.head = '{head_id, head_age, head_condition, head_priority};
				want = '0;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("check: result %0d arrived with no request waiting", results_seen);
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st || got.cnt !== want.cnt || got.hv !== want.hv ||
						got.head.id !== want.head.id || got.head.age !== want.head.age ||
						got.head.cond !== want.head.cond ||
						got.head.prio !== want.head.prio) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("check: result %0d expected st=%0d cnt=%0d hv=%0d head=%h/%0d/%0d/%0d",
								results_seen, want.st, want.cnt, want.hv, want.head.id,
								want.head.age, want.head.cond, want.head.prio);
							$display("check: result %0d got      st=%0d cnt=%0d hv=%0d head=%h/%0d/%0d/%0d",
								results_seen, got.st, got.cnt, got.hv, got.head.id,
								got.head.age, got.head.cond, got.head.prio);
						end
					end
				end
			end
			if ((start && !busy) || done)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("check: no progress for %0d cycles", STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Reset, directed table, random phases, drain and verdict.
	initial begin
		queue_req_t r;
		queue_res_t fixed;
		int insert_pct;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_NOP;
		entry_id = '0;
		entry_age = '0;
		entry_condition = '0;
		entry_priority = '0;
		target_priority = '0;
		idle_ok = 1'b1;
		fail_count = 0;
		stall_cycles = 0;
		results_seen = 0;
		insert_pct = 45;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests: extremes, every operation and the empty, same and not-found refusals.
		foreach (directed_plan[i]) begin
			r.fn = directed_plan[i].fn;
			r.ent = '{directed_plan[i].id, directed_plan[i].age, directed_plan[i].cond,
				directed_plan[i].prio};
			r.np = directed_plan[i].np;
			fixed = '{directed_plan[i].st, directed_plan[i].cnt, directed_plan[i].hv,
				directed_plan[i].head};
			issue_request(r, directed_plan[i].typed, fixed);
		end

		// Random requests in phases that fill, balance or drain the queue;
		// one long stretch runs back to back.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 50 == 0)
				insert_pct = ($urandom_range(2) == 0) ? 20 : ($urandom_range(1) ? 45 : 75);
			idle_ok = !(i >= 500 && i < 900);
			issue_request(pick_request(insert_pct), 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d results checked; %0d inserts (%0d refused full), %0d pops, %0d nops",
			results_seen, n_insert, n_full, n_pop, n_nop);
		$display("summary: %0d updates (%0d moved, %0d not found, %0d same), %0d empty refusals",
			n_update, n_moved, n_notfound, n_same, n_empty);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
